### hdl/rfa_pkg.sv
package rfa_pkg;

  localparam int MagWidth = 31;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_NONINT  = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_POWN,
    S_POWD,
    S_DONE
  } state_t;

endpackage

### hdl/rfa_divider.sv
// Restoring divider, one quotient bit per cycle.
module rfa_divider #(
  parameter int W = 2 * rfa_pkg::MagWidth + 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] count;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {rem, quo[W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### hdl/rational_fraction_alu_core.sv
// Rational arithmetic unit, one item at a time; add/sub/mul/div results are reduced by their gcd.
// Add/sub/mul/div form the cross products, then run Euclid steps and two final divisions by
// the gcd, all skipped for 0/0; power raises numerator and denominator in turn by repeated products.
// The shared restoring divider works one bit per cycle.
// Throughput: one item at a time; s_tready is low while an item is in work or waits.
// Reset: rst synchronous, active high; clears the sequencer and output valid.
module rational_fraction_alu_core #(
  parameter int MAG_WIDTH = rfa_pkg::MagWidth
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // opcode[2:0], a_negative, a_numerator, a_denominator, b_negative,
  // b_numerator, b_denominator, zero fill
  input  logic [8*((4*MAG_WIDTH+5+7)/8)-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // res_negative, res_numerator, res_denominator, status[1:0], zero fill
  output logic [8*((2*MAG_WIDTH+3+7)/8)-1:0] m_tdata
);

  localparam int M  = MAG_WIDTH;
  localparam int PW = 2 * M;      // exact product width
  localparam int W  = PW + 1;     // sum of two products
  localparam int OW = 2 * M + 3;

  rfa_pkg::state_t state, state_next;

  // Input fields
  logic [2:0]   in_op;
  logic         in_sa, in_sb;
  logic [M-1:0] in_an, in_ad, in_bn, in_bd;
  assign in_op = s_tdata[2:0];
  assign in_sa = s_tdata[3];
  assign in_an = s_tdata[4 +: M];
  assign in_ad = s_tdata[4+M +: M];
  assign in_sb = s_tdata[4+2*M];
  assign in_bn = s_tdata[5+2*M +: M];
  assign in_bd = s_tdata[5+3*M +: M];

  // Held operands
  logic [2:0]   op;
  logic         sa, sb;
  logic [M-1:0] an, ad, bn, bd;

  // Shared multiplier: one product a cycle, combinational; the products are registered
  logic [M-1:0]  mul_x, mul_y;
  logic [PW-1:0] prod;
  logic [PW-1:0] p, q;            // cross products
  logic [W-1:0]  num, den;        // fraction to reduce
  logic [W-1:0]  ga, gb;          // Euclid registers
  logic          neg;
  logic [1:0]    status;

  // Power
  logic [M-1:0]  pw_base, pw_acc;
  logic [M-1:0]  pw_exp;
  logic          pw_ovf;
  logic [M-1:0]  pw_n;
  logic [PW-1:0] pw_prod;

  // Divider
  logic         dv_start, dv_busy, dv_go;
  logic         dv_busy_d, dv_fin;
  logic [W-1:0] dv_n, dv_d, dv_q, dv_r;

  rfa_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_n), .divisor(dv_d),
    .busy(dv_busy), .quotient(dv_q), .remainder(dv_r)
  );

  // Result
  logic         res_neg;
  logic [M-1:0] res_n, res_d;
  logic [1:0]   res_st;

  assign s_tready = (state == rfa_pkg::S_IDLE) && !m_tvalid;

  always_comb begin
    mul_x = an;
    mul_y = bd;
    case (state)
      rfa_pkg::S_MUL0: begin
        mul_x = an;
        mul_y = (op == rfa_pkg::OP_MUL) ? bn : bd;
      end
      rfa_pkg::S_MUL1: begin
        mul_x = ad;
        mul_y = (op == rfa_pkg::OP_DIV) ? bd : bn;
      end
      rfa_pkg::S_MUL2: begin
        mul_x = ad;
        mul_y = (op == rfa_pkg::OP_DIV) ? bn : bd;
      end
      default: begin
        mul_x = pw_acc;
        mul_y = pw_base;
      end
    endcase
  end
  assign prod    = PW'(mul_x) * PW'(mul_y);
  assign pw_prod = prod;

  always_ff @(posedge clk) begin
    if (rst) state <= rfa_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    dv_start   = 1'b0;
    dv_n       = ga;
    dv_d       = gb;
    case (state)
      rfa_pkg::S_IDLE:
        if (s_tvalid && s_tready) begin
          if (in_op == rfa_pkg::OP_POW) state_next = rfa_pkg::S_POWN;
          else if (in_op > rfa_pkg::OP_POW) state_next = rfa_pkg::S_DONE;
          else state_next = rfa_pkg::S_MUL0;
        end
      rfa_pkg::S_MUL0: state_next = rfa_pkg::S_MUL1;
      rfa_pkg::S_MUL1: state_next = rfa_pkg::S_MUL2;
      rfa_pkg::S_MUL2: state_next = rfa_pkg::S_SUM;
      rfa_pkg::S_SUM:  state_next = rfa_pkg::S_GCD;
      rfa_pkg::S_GCD:
        if (!dv_busy && !dv_go && !dv_fin) begin
          if (gb == '0) begin
            if (ga == '0) state_next = rfa_pkg::S_DONE;
            else begin
              dv_start   = 1'b1;
              dv_n       = num;
              dv_d       = ga;
              state_next = rfa_pkg::S_DIVN;
            end
          end else dv_start = 1'b1;
        end
      rfa_pkg::S_DIVN:
        if (!dv_busy && !dv_go) begin
          dv_start   = 1'b1;
          dv_n       = den;
          dv_d       = ga;
          state_next = rfa_pkg::S_DIVD;
        end
      rfa_pkg::S_DIVD:
        if (!dv_busy && !dv_go) state_next = rfa_pkg::S_DONE;
      rfa_pkg::S_POWN:
        if (pw_exp == '0 || pw_ovf) state_next = rfa_pkg::S_POWD;
      rfa_pkg::S_POWD:
        if (pw_exp == '0 || pw_ovf) state_next = rfa_pkg::S_DONE;
      rfa_pkg::S_DONE: state_next = rfa_pkg::S_IDLE;
      default: state_next = rfa_pkg::S_IDLE;
    endcase
  end

  // dv_go is high in the cycle after start, in which busy is already high;
  // dv_fin marks the first cycle after the divider has finished
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_go     <= 1'b0;
      dv_busy_d <= 1'b0;
    end else begin
      dv_go     <= dv_start;
      dv_busy_d <= dv_busy;
    end
  end
  assign dv_fin = dv_busy_d & ~dv_busy;

  logic [W-1:0] sum_mag;
  logic         sum_neg;
  logic         sb_eff;
  always_comb begin
    sb_eff = (op == rfa_pkg::OP_SUB) ? ~sb : sb;
    if (sa == sb_eff) begin
      sum_mag = W'(p) + W'(q);
      sum_neg = (sum_mag == '0) ? 1'b0 : sa;
    end else if (p >= q) begin
      sum_mag = W'(p) - W'(q);
      sum_neg = (sum_mag == '0) ? 1'b0 : sa;
    end else begin
      sum_mag = W'(q) - W'(p);
      sum_neg = sb_eff;
    end
  end

  // Power step: exponent 0 finishes at once; base <= 1 sets the result to the base and ends the loop
  logic pw_trivial;
  assign pw_trivial = (pw_base <= M'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (state == rfa_pkg::S_DONE) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rfa_pkg::S_IDLE:
        if (s_tvalid && s_tready) begin
          op      <= in_op;
          sa      <= in_sa;
          sb      <= in_sb;
          an      <= in_an;
          ad      <= in_ad;
          bn      <= in_bn;
          bd      <= in_bd;
          res_neg <= 1'b0;
          res_n   <= '0;
          res_d   <= M'(1);
          res_st  <= rfa_pkg::ST_OK;
          pw_base <= in_sb ? in_ad : in_an;
          pw_n    <= in_sb ? in_an : in_ad;
          pw_acc  <= M'(1);
          pw_exp  <= in_bn;
          pw_ovf  <= 1'b0;
          status  <= rfa_pkg::ST_OK;
          neg     <= in_sa & in_bn[0];
        end
      rfa_pkg::S_MUL0: p <= prod;
      rfa_pkg::S_MUL1: q <= prod;
      rfa_pkg::S_MUL2: begin
        den <= W'(prod);
        gb  <= W'(prod);
      end
      rfa_pkg::S_SUM: begin
        if (op == rfa_pkg::OP_ADD || op == rfa_pkg::OP_SUB) begin
          num <= sum_mag;
          ga  <= sum_mag;
          neg <= sum_neg;
        end else begin
          num <= W'(p);
          ga  <= W'(p);
          neg <= sa ^ sb;
        end
      end
      rfa_pkg::S_GCD:
        if (!dv_busy && !dv_go && state_next == rfa_pkg::S_DONE) begin
          res_n  <= num[M-1:0];
          res_d  <= den[M-1:0];
          res_neg <= neg;
          status <= (num[W-1:M] != '0 || den[W-1:M] != '0) ?
                    rfa_pkg::ST_OVF : rfa_pkg::ST_OK;
        end else if (dv_go && !dv_busy) begin
          // no-op: divider still loading
        end
      rfa_pkg::S_DIVN:
        if (!dv_busy && !dv_go) num <= dv_q;
      rfa_pkg::S_DIVD:
        if (!dv_busy && !dv_go) begin
          res_n   <= num[M-1:0];
          res_d   <= dv_q[M-1:0];
          res_neg <= neg;
          status  <= (num[W-1:M] != '0 || dv_q[W-1:M] != '0) ?
                     rfa_pkg::ST_OVF : rfa_pkg::ST_OK;
        end
      rfa_pkg::S_POWN, rfa_pkg::S_POWD: begin
        if (pw_exp == '0 || pw_ovf) begin
          if (state == rfa_pkg::S_POWN) begin
            res_n   <= pw_ovf ? '0 : pw_acc;
            pw_base <= pw_n;
            pw_acc  <= M'(1);
            pw_exp  <= bn;
          end else begin
            res_d <= pw_ovf ? '0 : pw_acc;
          end
          if (pw_ovf) status <= rfa_pkg::ST_OVF;
          pw_ovf <= 1'b0;
        end else if (pw_trivial) begin
          pw_acc <= pw_base;
          pw_exp <= '0;
        end else begin
          if (pw_prod[PW-1:M] != '0) pw_ovf <= 1'b1;
          pw_acc <= pw_prod[M-1:0];
          pw_exp <= pw_exp - 1'b1;
        end
      end
      rfa_pkg::S_DONE: begin
        if (op == rfa_pkg::OP_POW) begin
          res_neg <= neg;
          res_st  <= (bd != M'(1)) ? rfa_pkg::ST_NONINT : status;
        end else if (op == rfa_pkg::OP_DIV && den == '0) begin
          res_st <= rfa_pkg::ST_ZERODEN;
        end else if (op <= rfa_pkg::OP_DIV) begin
          res_st <= status;
        end
      end
      default: ;
    endcase
    // Euclid step: (a, b) <= (b, a mod b)
    if (state == rfa_pkg::S_GCD && dv_fin) begin
      ga <= gb;
      gb <= dv_r;
    end
  end

  assign m_tdata = {{(8*((OW+7)/8) - OW){1'b0}}, res_st, res_d, res_n, res_neg};

endmodule
